>>> rtl/fbwh_pkg.sv
// ----------------------------------------------------------------------------
// fbwh_pkg
// Shared types and constants of the fixed-bin weighted histogram.
// ----------------------------------------------------------------------------
package fbwh_pkg;

  // bin store geometry
  localparam int MAX_BINS = 256;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int SUM_W    = 64;
  localparam int ENTRY_W  = 2 * SUM_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BINS      = 3'd0,
    CFG_RANGE_MIN     = 3'd1,
    CFG_RANGE_MAX     = 3'd2,
    CFG_BIN_SCALE     = 3'd3,
    CFG_OVERFLOW_MODE = 3'd4,
    CFG_ERROR_READOUT = 3'd5
  } cfg_idx_t;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // register reset values
  localparam logic [8:0]  NUM_BINS_RST  = 9'd256;
  localparam logic [31:0] RANGE_MIN_RST = 32'h0000_0000;
  localparam logic [31:0] RANGE_MAX_RST = 32'h0001_0000;
  localparam logic [31:0] BIN_SCALE_RST = 32'h0100_0000;

  // saturation limits of the sums
  localparam logic [SUM_W-1:0] WSUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] WSUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // first trial bit of the square root
  localparam logic [SUM_W-2:0] SQ_BIT_INIT = {1'b1, {(SUM_W-2){1'b0}}};

endpackage

>>> rtl/fbwh_ram.sv
// ----------------------------------------------------------------------------
// fbwh_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbwh_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/fixed_bin_weighted_histogram.sv
// sequence: an add in range runs decode, multiply, clamp, fetch and update; an add to
//   an edge bin or a read runs decode, fetch and update; clear, dropped sample or unknown
//   op finish in decode; square-root readout adds the bit-pair sqrt loop after update
// one operation at a time, busy stays high until the done cycle; the 32x32 multiplier is shared
// done is a one-cycle strobe, the receiver cannot stall
// reset: sync active-high rst clears config to defaults and all bins to zero via valid bits
// ----------------------------------------------------------------------------
// fixed_bin_weighted_histogram
// Weighted histogram with uniform Q16.16 bins, saturating weight and square
// sums per bin, bin read with optional square-root readout, bin clear.
// ----------------------------------------------------------------------------
module fixed_bin_weighted_histogram (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       op,
  input  logic signed [31:0]               sample,
  input  logic signed [31:0]               weight,
  input  logic [7:0]                       bin_select,
  // result channel
  output logic                             done,
  output logic [7:0]                       bin_index,
  output logic                             accepted,
  output logic signed [63:0]               weight_total,
  output logic [62:0]                      spread_total,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbwh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbwh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,   // range compares, bin offset, weight magnitude
    ST_MUL_BIN,  // multiplier: offset * bin_scale
    ST_CLAMP,    // bin from product, clamped to the last bin
    ST_FETCH,    // ram read of the bin, multiplier: |weight|^2
    ST_UPDATE,   // saturating sums, write back on an add
    ST_SQRT      // one bit pair of the integer square root per cycle
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0]         num_bins;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;
  logic [31:0]        bin_scale;
  logic               overflow_mode;
  logic               error_readout;

  // latched command
  fbwh_pkg::op_t      op_r;
  logic signed [31:0] sample_r;
  logic signed [31:0] weight_r;
  logic [7:0]         sel_r;

  // working registers
  logic [31:0]                  diff_r;
  logic [31:0]                  mag_r;
  logic [63:0]                  prod;
  logic [fbwh_pkg::BIN_W-1:0]   bin_r;
  logic [fbwh_pkg::MAX_BINS-1:0] bin_valid;
  logic [62:0]                  sq_v;
  logic [62:0]                  sq_res;
  logic [62:0]                  sq_bit;

  // combinational
  logic [fbwh_pkg::BIN_W-1:0]   last_bin;
  logic                         sel_oor;
  logic [31:0]                  mul_a;
  logic [31:0]                  mul_b;
  logic [63:0]                  mul_out;
  logic signed [63:0]           old_w;
  logic [63:0]                  old_s;
  logic signed [64:0]           wsum;
  logic [63:0]                  ssum;
  logic [63:0]                  new_w;
  logic [63:0]                  new_s;
  logic [63:0]                  upd_w;
  logic [63:0]                  upd_s;
  logic [63:0]                  sq_trial;
  logic                         sq_take;
  logic [62:0]                  sq_v_next;
  logic [62:0]                  sq_res_next;

  // bin store
  logic                         ram_wr_en;
  logic [fbwh_pkg::BIN_W-1:0]   ram_wr_addr;
  logic [fbwh_pkg::ENTRY_W-1:0] ram_wr_data;
  logic [fbwh_pkg::ENTRY_W-1:0] ram_rd_data;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins      <= fbwh_pkg::NUM_BINS_RST;
      range_min     <= fbwh_pkg::RANGE_MIN_RST;
      range_max     <= fbwh_pkg::RANGE_MAX_RST;
      bin_scale     <= fbwh_pkg::BIN_SCALE_RST;
      overflow_mode <= 1'b0;
      error_readout <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fbwh_pkg::cfg_idx_t'(cfg_index))
        fbwh_pkg::CFG_NUM_BINS:      num_bins      <= cfg_data[8:0];
        fbwh_pkg::CFG_RANGE_MIN:     range_min     <= cfg_data;
        fbwh_pkg::CFG_RANGE_MAX:     range_max     <= cfg_data;
        fbwh_pkg::CFG_BIN_SCALE:     bin_scale     <= cfg_data;
        fbwh_pkg::CFG_OVERFLOW_MODE: overflow_mode <= cfg_data[0];
        fbwh_pkg::CFG_ERROR_READOUT: error_readout <= cfg_data[0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // last bin in use: zero bins act as one, more than the store holds is capped
  always_comb begin
    if (num_bins == '0) begin
      last_bin = '0;
    end else if (32'(num_bins) > 32'(fbwh_pkg::MAX_BINS)) begin
      last_bin = fbwh_pkg::BIN_W'(fbwh_pkg::MAX_BINS - 1);
    end else begin
      last_bin = fbwh_pkg::BIN_W'(num_bins - 9'd1);
    end
  end

  assign sel_oor = (32'(sel_r) > 32'(last_bin));

  // ---------------------------------------------------------------------------
  // shared multiplier: bin product first, then the weight square
  // ---------------------------------------------------------------------------
  assign mul_a   = (state == ST_MUL_BIN) ? diff_r    : mag_r;
  assign mul_b   = (state == ST_MUL_BIN) ? bin_scale : mag_r;
  assign mul_out = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // saturating accumulate; an entry never written reads as zero
  // ---------------------------------------------------------------------------
  assign old_w = bin_valid[bin_r] ? ram_rd_data[fbwh_pkg::ENTRY_W-1:fbwh_pkg::SUM_W] : '0;
  assign old_s = bin_valid[bin_r] ? ram_rd_data[fbwh_pkg::SUM_W-1:0] : '0;

  assign wsum = 65'(old_w) + 65'(weight_r);
  assign ssum = old_s + 64'(prod[63:16]);

  always_comb begin
    if (wsum[64] != wsum[63]) begin
      new_w = wsum[64] ? fbwh_pkg::WSUM_MIN : fbwh_pkg::WSUM_MAX;
    end else begin
      new_w = wsum[63:0];
    end
    // square sum never exceeds the signed max, so bit 63 flags overflow
    new_s = ssum[63] ? fbwh_pkg::WSUM_MAX : ssum;
    upd_w = (op_r == fbwh_pkg::OP_ADD) ? new_w : old_w;
    upd_s = (op_r == fbwh_pkg::OP_ADD) ? new_s : old_s;
  end

  // bin store writes: sum update, or zeroing of a cleared bin
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = bin_r;
    ram_wr_data = {new_w, new_s};
    if (state == ST_UPDATE && op_r == fbwh_pkg::OP_ADD) begin
      ram_wr_en = 1'b1;
    end else if (state == ST_DECODE && op_r == fbwh_pkg::OP_CLEAR && !sel_oor) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = fbwh_pkg::BIN_W'(sel_r);
      ram_wr_data = '0;
    end
  end

  fbwh_ram #(
    .WIDTH (fbwh_pkg::ENTRY_W),
    .DEPTH (fbwh_pkg::MAX_BINS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (bin_r),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // integer square root step, one result bit per cycle
  // ---------------------------------------------------------------------------
  assign sq_trial = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_take  = ({1'b0, sq_v} >= sq_trial);

  always_comb begin
    if (sq_take) begin
      sq_v_next   = sq_v - sq_trial[62:0];
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      bin_valid <= '0;
    end else begin
      done <= 1'b0;
      if (ram_wr_en) begin
        bin_valid[ram_wr_addr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_r     <= fbwh_pkg::op_t'(op);
            sample_r <= sample;
            weight_r <= weight;
            sel_r    <= bin_select;
            state    <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          diff_r <= 32'(sample_r - range_min);
          mag_r  <= weight_r[31] ? 32'(-weight_r) : 32'(weight_r);
          unique case (op_r)
            fbwh_pkg::OP_ADD: begin
              if (sample_r < range_min || sample_r >= range_max) begin
                if (overflow_mode) begin
                  // below the range lands in bin 0, at or above the top in the last
                  bin_r <= (sample_r < range_min) ? '0 : last_bin;
                  state <= ST_FETCH;
                end else begin
                  // dropped sample
                  done         <= 1'b1;
                  bin_index    <= '0;
                  accepted     <= 1'b0;
                  weight_total <= '0;
                  spread_total <= '0;
                  state        <= ST_IDLE;
                end
              end else begin
                state <= ST_MUL_BIN;
              end
            end
            fbwh_pkg::OP_READ: begin
              if (sel_oor) begin
                done         <= 1'b1;
                bin_index    <= sel_r;
                accepted     <= 1'b0;
                weight_total <= '0;
                spread_total <= '0;
                state        <= ST_IDLE;
              end else begin
                bin_r <= fbwh_pkg::BIN_W'(sel_r);
                state <= ST_FETCH;
              end
            end
            fbwh_pkg::OP_CLEAR: begin
              // zeroed bin reads back as zero in either readout form
              done         <= 1'b1;
              bin_index    <= sel_r;
              accepted     <= !sel_oor;
              weight_total <= '0;
              spread_total <= '0;
              state        <= ST_IDLE;
            end
            default: begin
              // unknown op: no change, all-zero result
              done         <= 1'b1;
              bin_index    <= '0;
              accepted     <= 1'b0;
              weight_total <= '0;
              spread_total <= '0;
              state        <= ST_IDLE;
            end
          endcase
        end

        ST_MUL_BIN: begin
          prod  <= mul_out;
          state <= ST_CLAMP;
        end

        ST_CLAMP: begin
          // bin = floor(offset * scale / 2^32)
          if (prod[63:32] > 32'(last_bin)) begin
            bin_r <= last_bin;
          end else begin
            bin_r <= prod[fbwh_pkg::BIN_W+31:32];
          end
          state <= ST_FETCH;
        end

        ST_FETCH: begin
          prod  <= mul_out;
          state <= ST_UPDATE;
        end

        ST_UPDATE: begin
          bin_index    <= 8'(bin_r);
          accepted     <= 1'b1;
          weight_total <= upd_w;
          if (error_readout) begin
            sq_v   <= upd_s[62:0];
            sq_res <= '0;
            sq_bit <= fbwh_pkg::SQ_BIT_INIT;
            state  <= ST_SQRT;
          end else begin
            spread_total <= upd_s[62:0];
            done         <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        ST_SQRT: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            spread_total <= sq_res_next;
            done         <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result only closes out an operation that was in flight
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != ST_IDLE))
    else $error("result strobe without an operation in flight");

  // a transfer on the command channel makes the block busy next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not start the sequencer");

  // counted results always name a bin in use
  assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (32'(bin_index) <= 32'(last_bin)))
    else $error("accepted result outside the bins in use");

  // the store is only written while an operation runs
  assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == ST_DECODE || state == ST_UPDATE))
    else $error("bin store written outside an operation");

  // square sum stays within the signed limit
  assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> !ram_wr_data[fbwh_pkg::SUM_W-1])
    else $error("square sum above saturation limit");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the fixed-bin weighted histogram against a cycle-free predictor of
// its bins: a short directed run over the corner cases, then random phases
// with fresh register settings, bursty commands and full result checking.
// ----------------------------------------------------------------------------
module testbench;

  // run limits: the slowest legal run (square-root readout on every item,
  // longest sender gap) stays far below the cycle limit
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 64;

  // codes with no member in the package enums
  localparam logic [1:0] OP_UNDEF   = 2'd3;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  localparam logic signed [31:0] UNIT_WEIGHT = 32'sh0001_0000;

  typedef enum logic [1:0] {ACT_CMD, ACT_CFG, ACT_HOLD} act_kind_t;

  // one pending sender action: a command, a register write, or a hold
  // until every outstanding result has come back
  typedef struct {
    act_kind_t          kind;
    logic [1:0]         opc;
    logic signed [31:0] smp;
    logic signed [31:0] wgt;
    logic [7:0]         sel;
    logic [2:0]         reg_idx;
    logic [31:0]        reg_val;
    int unsigned        gap_after;
  } stim_t;

  // one bin report as the block should put it out
  typedef struct {
    logic [7:0]  bin_index;
    logic        accepted;
    logic [63:0] weight_total;
    logic [62:0] spread_total;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            start = 1'b0;
  logic                            busy;
  logic [1:0]                      op = fbwh_pkg::OP_ADD;
  logic signed [31:0]              sample = '0;
  logic signed [31:0]              weight = '0;
  logic [7:0]                      bin_select = '0;
  logic                            done;
  logic [7:0]                      bin_index;
  logic                            accepted;
  logic signed [63:0]              weight_total;
  logic [62:0]                     spread_total;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fbwh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fbwh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fixed_bin_weighted_histogram dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .sample       (sample),
    .weight       (weight),
    .bin_select   (bin_select),
    .done         (done),
    .bin_index    (bin_index),
    .accepted     (accepted),
    .weight_total (weight_total),
    .spread_total (spread_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // sender actions still to go, and bin reports owed by the block
  stim_t       bin_ops_pending[$];
  bin_report_t bin_reports_due[$];

  // shadow copy of the block: registers and both bin stores
  logic [8:0]         shadow_nbins;
  logic signed [31:0] shadow_lo;
  logic signed [31:0] shadow_hi;
  logic [31:0]        shadow_scale;
  logic               shadow_edge_mode;
  logic               shadow_sqrt_mode;
  logic signed [63:0] shadow_wsum [fbwh_pkg::MAX_BINS];
  logic [63:0]        shadow_ssum [fbwh_pkg::MAX_BINS];

  // handshakes seen at the last rising edge, used by the driver
  logic cmd_xfer = 1'b0;
  logic cfg_xfer = 1'b0;

  int fault_count = 0;
  int cycle_count = 0;

  // stimulus planning state: burst shaping and the settings being queued
  int          burst_left = 0;
  logic        steady_run = 1'b0;
  int unsigned gap_left = 0;
  int          plan_lo = 0;
  int          plan_hi = 32'h0001_0000;
  int          plan_nb = fbwh_pkg::MAX_BINS;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // bins actually in use: zero counts as one, anything past the store clamps
  function automatic int unsigned bins_active();
    if (shadow_nbins == 0) return 1;
    if (shadow_nbins > fbwh_pkg::MAX_BINS) return fbwh_pkg::MAX_BINS;
    return shadow_nbins;
  endfunction

  // square sum as reported: raw, or floor square root when readout is set
  function automatic logic [62:0] spread_of(input logic [63:0] sq);
    logic [63:0] root;
    logic [63:0] trial;
    int          k;
    if (!shadow_sqrt_mode) return sq[62:0];
    root = '0;
    for (k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= sq) root = trial;
    end
    return root[62:0];
  endfunction

  task automatic shadow_reset();
    shadow_nbins     = fbwh_pkg::NUM_BINS_RST;
    shadow_lo        = fbwh_pkg::RANGE_MIN_RST;
    shadow_hi        = fbwh_pkg::RANGE_MAX_RST;
    shadow_scale     = fbwh_pkg::BIN_SCALE_RST;
    shadow_edge_mode = 1'b0;
    shadow_sqrt_mode = 1'b0;
    for (int i = 0; i < fbwh_pkg::MAX_BINS; i++) begin
      shadow_wsum[i] = '0;
      shadow_ssum[i] = '0;
    end
  endtask

  task automatic shadow_write(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      fbwh_pkg::CFG_NUM_BINS:      shadow_nbins     = val[8:0];
      fbwh_pkg::CFG_RANGE_MIN:     shadow_lo        = val;
      fbwh_pkg::CFG_RANGE_MAX:     shadow_hi        = val;
      fbwh_pkg::CFG_BIN_SCALE:     shadow_scale     = val;
      fbwh_pkg::CFG_OVERFLOW_MODE: shadow_edge_mode = val[0];
      fbwh_pkg::CFG_ERROR_READOUT: shadow_sqrt_mode = val[0];
      default: ;
    endcase
  endtask

  // applies one command to the shadow bins and returns the report it causes
  task automatic predict_bin_op(input logic [1:0] opc, input logic signed [31:0] smp,
                                input logic signed [31:0] wgt, input logic [7:0] sel,
                                output bin_report_t rpt);
    logic signed [63:0] s64, lo64, hi64, w64;
    logic signed [64:0] wnext;
    logic [64:0]        snext;
    logic [63:0]        diff, mag, sq, bin_w;
    logic [95:0]        prod;
    logic [7:0]         b;
    logic               hit;
    int unsigned        nb;
    rpt.bin_index    = '0;
    rpt.accepted     = 1'b0;
    rpt.weight_total = '0;
    rpt.spread_total = '0;
    nb = bins_active();
    case (opc)
      fbwh_pkg::OP_ADD: begin
        s64  = smp;
        lo64 = shadow_lo;
        hi64 = shadow_hi;
        hit  = 1'b1;
        bin_w = '0;
        // outside the range: edge bin or dropped; an inverted range always lands here
        if (s64 < lo64) begin
          hit = shadow_edge_mode;
        end else if (s64 >= hi64) begin
          hit   = shadow_edge_mode;
          bin_w = nb - 1;
        end else begin
          diff  = s64 - lo64;
          prod  = diff * shadow_scale;
          bin_w = prod[95:32];
          if (bin_w > nb - 1) bin_w = nb - 1;
        end
        if (hit) begin
          b     = bin_w[7:0];
          w64   = wgt;
          wnext = shadow_wsum[b] + w64;
          if (wnext[64] != wnext[63])
            shadow_wsum[b] = wnext[64] ? fbwh_pkg::WSUM_MIN : fbwh_pkg::WSUM_MAX;
          else
            shadow_wsum[b] = wnext[63:0];
          mag   = (w64 < 0) ? -w64 : w64;
          sq    = (mag * mag) >> 16;
          snext = shadow_ssum[b] + sq;
          shadow_ssum[b] = (snext > fbwh_pkg::WSUM_MAX) ? fbwh_pkg::WSUM_MAX : snext[63:0];
          rpt.bin_index    = b;
          rpt.accepted     = 1'b1;
          rpt.weight_total = shadow_wsum[b];
          rpt.spread_total = spread_of(shadow_ssum[b]);
        end
      end
      fbwh_pkg::OP_READ, fbwh_pkg::OP_CLEAR: begin
        rpt.bin_index = sel;
        // a bin past the ones in use is left alone and reported empty
        if (sel < nb) begin
          if (opc == fbwh_pkg::OP_CLEAR) begin
            shadow_wsum[sel] = '0;
            shadow_ssum[sel] = '0;
          end
          rpt.accepted     = 1'b1;
          rpt.weight_total = shadow_wsum[sel];
          rpt.spread_total = spread_of(shadow_ssum[sel]);
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // queues a command; bursts of random length mostly end in a random gap, except
  // in steady stretches where commands follow back to back
  task automatic queue_op(input logic [1:0] opc, input logic signed [31:0] smp,
                          input logic signed [31:0] wgt, input logic [7:0] sel);
    stim_t s;
    s.kind      = ACT_CMD;
    s.opc       = opc;
    s.smp       = smp;
    s.wgt       = wgt;
    s.sel       = sel;
    s.reg_idx   = '0;
    s.reg_val   = '0;
    s.gap_after = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_run && $urandom_range(0, 3) != 0) s.gap_after = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
    bin_ops_pending.push_back(s);
  endtask

  // register writes and holds both wait for the block to drain first
  task automatic queue_reg(input logic [2:0] idx, input logic [31:0] val);
    stim_t s;
    s = '{kind: ACT_CFG, opc: fbwh_pkg::OP_ADD, smp: '0, wgt: '0, sel: '0,
          reg_idx: idx, reg_val: val, gap_after: 0};
    bin_ops_pending.push_back(s);
  endtask

  task automatic queue_hold();
    stim_t s;
    s = '{kind: ACT_HOLD, opc: fbwh_pkg::OP_ADD, smp: '0, wgt: '0, sel: '0,
          reg_idx: '0, reg_val: '0, gap_after: 0};
    bin_ops_pending.push_back(s);
  endtask

  // mostly inside the planned range, some right at its edges, some anywhere
  function automatic logic signed [31:0] draw_sample();
    longint span;
    int     pick;
    span = plan_hi;
    span = span - plan_lo;
    pick = $urandom_range(0, 9);
    if (pick < 7 && span > 0) return plan_lo + $urandom_range(0, span - 1);
    if (pick == 7) begin
      case ($urandom_range(0, 3))
        0:       return plan_lo - 1;
        1:       return plan_lo;
        2:       return plan_hi - 1;
        default: return plan_hi;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [31:0] draw_weight();
    case ($urandom_range(0, 7))
      0:       return UNIT_WEIGHT;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3, 4, 5: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] draw_select();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, plan_nb - 1);
  endfunction

  // --------------------------------------------------------------------------
  // driver: inputs change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_blk
    logic  start_n;
    logic  cfg_valid_n;
    stim_t head;
    start_n     = start;
    cfg_valid_n = cfg_valid;
    if (rst) begin
      start_n     = 1'b0;
      cfg_valid_n = 1'b0;
    end else begin
      // drop start or valid once the last rising edge took the transfer
      if (cmd_xfer) start_n = 1'b0;
      if (cfg_xfer) cfg_valid_n = 1'b0;
      if (!start_n && !cfg_valid_n && bin_ops_pending.size() != 0) begin
        head = bin_ops_pending[0];
        if (gap_left != 0) begin
          gap_left--;
        end else if (head.kind == ACT_CMD) begin
          op         <= head.opc;
          sample     <= head.smp;
          weight     <= head.wgt;
          bin_select <= head.sel;
          start_n    = 1'b1;
          gap_left   = head.gap_after;
          void'(bin_ops_pending.pop_front());
        end else if (bin_reports_due.size() == 0 && !busy) begin
          // block idle: registers may change, a hold simply ends here
          if (head.kind == ACT_CFG) begin
            cfg_index   <= head.reg_idx;
            cfg_data    <= head.reg_val;
            cfg_valid_n = 1'b1;
          end
          void'(bin_ops_pending.pop_front());
        end
      end
    end
    start     <= start_n;
    cfg_valid <= cfg_valid_n;
  end

  // --------------------------------------------------------------------------
  // monitor: transfers and results are sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_blk
    bin_report_t want;
    if (rst) begin
      shadow_reset();
      cmd_xfer <= 1'b0;
      cfg_xfer <= 1'b0;
    end else begin
      // result strobe: compare against the oldest outstanding report
      if (done === 1'b1) begin
        if (bin_reports_due.size() == 0) begin
          $error("result with no command outstanding: bin_index %0d", bin_index);
          fault_count++;
        end else begin
          want = bin_reports_due.pop_front();
          if (bin_index !== want.bin_index) begin
            $error("bin_index mismatch: expected %0d, actual %0d",
                   want.bin_index, bin_index);
            fault_count++;
          end
          if (accepted !== want.accepted) begin
            $error("accepted mismatch: expected %0d, actual %0d",
                   want.accepted, accepted);
            fault_count++;
          end
          if (weight_total !== want.weight_total) begin
            $error("weight_total mismatch: expected %0d, actual %0d",
                   $signed(want.weight_total), weight_total);
            fault_count++;
          end
          if (spread_total !== want.spread_total) begin
            $error("spread_total mismatch: expected %0d, actual %0d",
                   want.spread_total, spread_total);
            fault_count++;
          end
        end
      end
      // register write transfer updates the shadow settings
      if (cfg_valid && cfg_ready) shadow_write(cfg_index, cfg_data);
      // command transfer: predict now, with the settings in force
      if (start && !busy) begin
        predict_bin_op(op, sample, weight, bin_select, want);
        bin_reports_due.push_back(want);
      end
      cmd_xfer <= start && !busy;
      cfg_xfer <= cfg_valid && cfg_ready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[fixed_bin_weighted_histogram] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         phase, n, rep, r;
    longint     span_l, scale_l, nb_l;
    logic [8:0] nb_raw;
    logic signed [31:0] hot_sample;

    // default settings: 256 bins over [0, 1.0)
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_0000, UNIT_WEIGHT, 8'd0);     // lower edge, bin 0
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_FFFF, 32'sh7FFF_FFFF, 8'd0);  // top bin, largest
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_FFFF, 32'sh8000_0000, 8'd0);  // same bin, most neg
    queue_op(fbwh_pkg::OP_ADD, 32'sh0001_0000, UNIT_WEIGHT, 8'd0);     // upper edge: dropped
    queue_op(fbwh_pkg::OP_ADD, 32'shFFFF_FFFF, UNIT_WEIGHT, 8'd0);     // just below: dropped
    queue_op(fbwh_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh0123_4567, 8'hFF);
    queue_op(fbwh_pkg::OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 8'hFF);
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_8000, 32'sh0000_0000, 8'd0);  // zero weight
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_8000, UNIT_WEIGHT, 8'd0);     // same bin again
    queue_op(fbwh_pkg::OP_READ, '0, '0, 8'd255);
    queue_op(fbwh_pkg::OP_READ, '0, '0, 8'd128);
    queue_op(fbwh_pkg::OP_CLEAR, '0, '0, 8'd128);
    queue_op(fbwh_pkg::OP_READ, '0, '0, 8'd128);
    queue_op(OP_UNDEF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 8'hFF);

    // four bins, out-of-range samples to the edge bins, square-root readout
    queue_reg(fbwh_pkg::CFG_NUM_BINS, 32'd4);
    queue_reg(fbwh_pkg::CFG_OVERFLOW_MODE, 32'd1);
    queue_reg(fbwh_pkg::CFG_ERROR_READOUT, 32'd1);
    queue_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_op(fbwh_pkg::OP_ADD, 32'sh8000_0000, UNIT_WEIGHT, 8'd0);     // below -> bin 0
    queue_op(fbwh_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'd0);  // above -> last bin
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_C000, 32'shFFFF_0000, 8'd0);  // in range, clamped
    queue_op(fbwh_pkg::OP_READ, '0, '0, 8'd3);
    queue_op(fbwh_pkg::OP_READ, '0, '0, 8'd4);                         // past the bins in use
    queue_op(fbwh_pkg::OP_CLEAR, '0, '0, 8'd255);

    // zero bin count, inverted range, zero scale
    queue_reg(fbwh_pkg::CFG_NUM_BINS, 32'd0);
    queue_reg(fbwh_pkg::CFG_RANGE_MIN, 32'h0001_0000);
    queue_reg(fbwh_pkg::CFG_RANGE_MAX, 32'h0000_0000);
    queue_reg(fbwh_pkg::CFG_BIN_SCALE, 32'h0000_0000);
    queue_op(fbwh_pkg::OP_ADD, 32'sh0000_8000, UNIT_WEIGHT, 8'd0);
    queue_op(fbwh_pkg::OP_ADD, 32'sh0002_0000, UNIT_WEIGHT, 8'd0);

    // oversized bin count, widest range, largest scale, plain readout
    queue_reg(fbwh_pkg::CFG_NUM_BINS, 32'd511);
    queue_reg(fbwh_pkg::CFG_RANGE_MIN, 32'h8000_0000);
    queue_reg(fbwh_pkg::CFG_RANGE_MAX, 32'h7FFF_FFFF);
    queue_reg(fbwh_pkg::CFG_BIN_SCALE, 32'hFFFF_FFFF);
    queue_reg(fbwh_pkg::CFG_OVERFLOW_MODE, 32'd0);
    queue_reg(fbwh_pkg::CFG_ERROR_READOUT, 32'd0);
    queue_op(fbwh_pkg::OP_ADD, 32'sh7FFF_FFFE, UNIT_WEIGHT, 8'd0);
    queue_op(fbwh_pkg::OP_READ, '0, '0, 8'd255);

    // random phases, each with fresh settings
    for (phase = 0; phase < 6; phase++) begin
      steady_run = (phase == 2);
      burst_left = 0;

      r = $urandom_range(0, 5);
      case (r)
        0:       nb_raw = 9'd1;
        1:       nb_raw = 9'd256;
        2:       nb_raw = 9'd0;
        3:       nb_raw = $urandom_range(257, 511);
        default: nb_raw = $urandom_range(2, 64);
      endcase
      plan_nb = (nb_raw == 0) ? 1 :
                ((nb_raw > fbwh_pkg::MAX_BINS) ? fbwh_pkg::MAX_BINS : nb_raw);

      r = $urandom_range(0, 7);
      if (r == 0) begin
        plan_lo = 32'h8000_0000;
        plan_hi = 32'h7FFF_FFFF;
      end else if (r == 1) begin
        // empty or inverted range
        plan_lo = $urandom;
        plan_hi = plan_lo - $urandom_range(0, 32'h0001_0000);
      end else begin
        plan_lo = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        plan_hi = plan_lo + $urandom_range(1, 32'h0010_0000);
      end

      // bins per unit to match the range, sometimes just any scale
      span_l = plan_hi;
      span_l = span_l - plan_lo;
      nb_l   = plan_nb;
      scale_l = (span_l > 0) ? (nb_l << 32) / span_l : 64'hFFFF_FFFF;
      if (scale_l > 64'hFFFF_FFFF) scale_l = 64'hFFFF_FFFF;
      if ($urandom_range(0, 4) == 0) scale_l = $urandom;

      // stray upper bits on the narrow registers now and then
      queue_reg(fbwh_pkg::CFG_NUM_BINS, ($urandom_range(0, 3) == 0) ?
                ({$urandom} & 32'hFFFF_FE00) | nb_raw : {23'd0, nb_raw});
      queue_reg(fbwh_pkg::CFG_RANGE_MIN, plan_lo);
      queue_reg(fbwh_pkg::CFG_RANGE_MAX, plan_hi);
      queue_reg(fbwh_pkg::CFG_BIN_SCALE, scale_l[31:0]);
      queue_reg(fbwh_pkg::CFG_OVERFLOW_MODE, ($urandom_range(0, 3) == 0) ? $urandom :
                $urandom_range(0, 1));
      queue_reg(fbwh_pkg::CFG_ERROR_READOUT, ($urandom_range(0, 2) == 0) ? 32'd1 : 32'd0);

      n = 0;
      while (n < 125) begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          hot_sample = draw_sample();
          // a run of hits on one bin now and then
          rep = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1;
          repeat (rep) queue_op(fbwh_pkg::OP_ADD, hot_sample, draw_weight(), $urandom);
          n += rep;
        end else begin
          if (r < 88)      queue_op(fbwh_pkg::OP_READ, $urandom, $urandom, draw_select());
          else if (r < 95) queue_op(fbwh_pkg::OP_CLEAR, $urandom, $urandom, draw_select());
          else             queue_op(OP_UNDEF, $urandom, $urandom, $urandom);
          n++;
        end
        // the sender waits out every outstanding result now and then
        if ($urandom_range(0, 39) == 0) queue_hold();
      end
    end

    // reset held from the start of the run, released on a falling edge
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (bin_ops_pending.size() != 0 || start || bin_reports_due.size() != 0)
      @(posedge clk);
    // quiet tail: no stray result may show up
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("[fixed_bin_weighted_histogram] OK");
    end else begin
      $display("[fixed_bin_weighted_histogram] ERROR");
    end
    $finish;
  end

endmodule
